[hw/rtl/tawof_pkg.sv]
// Shared constants, types and CORDIC tables of the turn-aware wall object filter.
package tawof_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int XW = 38;  // CORDIC x/y datapath width
  localparam int ZW = 36;  // CORDIC angle width, Q30 radians
  localparam int DW = 37;  // heading difference width

  localparam logic signed [ZW-1:0] ANG_PI      = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(64'sd1686629713);
  localparam logic signed [DW-1:0] ANG_TWO_PI  = DW'(64'sd6746518852);
  localparam logic signed [XW-1:0] CORDIC_ONE  = XW'(268435456);

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
  };

  localparam int REG_IDX_W = 4;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FILTER_ENABLE    = 4'd0,
    REG_TURN_THR_ONE     = 4'd1,
    REG_TURN_THR_TWO     = 4'd2,
    REG_TURN_THR_THREE   = 4'd3,
    REG_MEDIUM_SKIP_GAIN = 4'd4,
    REG_BASE_SKIP_DIST   = 4'd5,
    REG_WHEEL_BASE       = 4'd6,
    REG_MAX_STEER        = 4'd7
  } tawof_reg_e;

  // Fields that ride along the pipeline up to stage A
  typedef struct packed {
    logic [15:0]        sp;
    logic [14:0]        as;
    logic               steer_pos;
    logic signed [15:0] head;
    logic               wall;
    logic               zero_st;
    logic               low;
  } carry_t;

  typedef struct packed {
    carry_t      c;
    logic        huge;
    logic        zero_vec;
    logic [48:0] d2;
  } side_t;

endpackage

[hw/rtl/tawof_if.sv]
// Channel interfaces of the turn-aware wall object filter.
interface tawof_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] obj_x;
  logic signed [31:0] obj_y;
  logic [15:0]        obj_width;
  logic [15:0]        obj_length;
  logic signed [31:0] vehicle_x;
  logic signed [31:0] vehicle_y;
  logic signed [15:0] vehicle_heading;
  logic signed [15:0] vehicle_speed;
  logic signed [14:0] steer_angle;
  modport source (output valid, obj_x, obj_y, obj_width, obj_length, vehicle_x, vehicle_y,
                  vehicle_heading, vehicle_speed, steer_angle, input ready);
  modport sink (input valid, obj_x, obj_y, obj_width, obj_length, vehicle_x, vehicle_y,
                vehicle_heading, vehicle_speed, steer_angle, output ready);
endinterface

interface tawof_out_if;
  logic       valid;
  logic       ready;
  logic       keep_object;
  logic [1:0] turn_level;
  modport source (output valid, keep_object, turn_level, input ready);
  modport sink (input valid, keep_object, turn_level, output ready);
endinterface

interface tawof_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/tawof_cordic.sv]
// Pipelined CORDIC, one iteration per register stage, rotation or vectoring mode.
module tawof_cordic (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic                           vectoring_i,
  input  logic signed [tawof_pkg::XW-1:0] x_i,
  input  logic signed [tawof_pkg::XW-1:0] y_i,
  input  logic signed [tawof_pkg::ZW-1:0] z_i,
  output logic signed [tawof_pkg::XW-1:0] x_o,
  output logic signed [tawof_pkg::XW-1:0] y_o,
  output logic signed [tawof_pkg::ZW-1:0] z_o
);

  logic signed [tawof_pkg::XW-1:0] x_q [tawof_pkg::CORDIC_STAGES];
  logic signed [tawof_pkg::XW-1:0] y_q [tawof_pkg::CORDIC_STAGES];
  logic signed [tawof_pkg::ZW-1:0] z_q [tawof_pkg::CORDIC_STAGES];

  for (genvar i = 0; i < tawof_pkg::CORDIC_STAGES; i++) begin : g_stage
    logic signed [tawof_pkg::XW-1:0] xin, yin, xs, ys;
    logic signed [tawof_pkg::ZW-1:0] zin, ang;
    logic                            sigma;

    if (i == 0) begin : g_first
      assign xin = x_i;
      assign yin = y_i;
      assign zin = z_i;
    end else begin : g_next
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
    end

    assign xs  = xin >>> i;
    assign ys  = yin >>> i;
    assign ang = $signed(tawof_pkg::ZW'(tawof_pkg::ATAN_TAB[i]));
    // rotate toward zero angle, or toward zero y when vectoring
    assign sigma = vectoring_i ? !(yin > 0) : (zin >= 0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= sigma ? xin - ys : xin + ys;
        y_q[i] <= sigma ? yin + xs : yin - xs;
        z_q[i] <= sigma ? zin - ang : zin + ang;
      end
    end
  end

  assign x_o = x_q[tawof_pkg::CORDIC_STAGES-1];
  assign y_o = y_q[tawof_pkg::CORDIC_STAGES-1];
  assign z_o = z_q[tawof_pkg::CORDIC_STAGES-1];

endmodule

[hw/rtl/turn_aware_wall_object_filter.sv]
// Top level of the turn-aware wall object filter.
// Accepts one object beat per cycle while the result side is not stalled, and returns one
// result beat per object, in order. The pipeline holds input, normalize, multiply,
// threshold-compare and output stages around the two CORDIC pipelines (bearing and steer
// tangent). A stalled result holds the whole pipeline in place. The turn level comes from
// comparing the yaw-rate quotient against the thresholds by cross-multiplication;
// configuration writes take effect for objects accepted after the write and must only be
// issued while no object is in flight.
module turn_aware_wall_object_filter (
  input logic  clk_i,
  input logic  rst_ni,
  tawof_in_if.sink    item_i,
  tawof_out_if.source result_o,
  tawof_cfg_if.sink   cfg_i
);

  localparam int NS = tawof_pkg::CORDIC_STAGES;
  localparam int XW = tawof_pkg::XW;
  localparam int ZW = tawof_pkg::ZW;
  localparam int DW = tawof_pkg::DW;

  // ---------------- configuration ----------------
  logic        filt_en_q;
  logic [15:0] thr1_q, thr2_q, thr3_q, bsd_q;
  logic [7:0]  gain_q;
  logic [10:0] wb_q;
  logic [13:0] ms_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_en_q <= 1'b1;
      thr1_q    <= 16'd205;
      thr2_q    <= 16'd819;
      thr3_q    <= 16'd2048;
      gain_q    <= 8'd40;
      bsd_q     <= 16'd12800;
      wb_q      <= 11'd691;
      ms_q      <= 14'd4915;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        tawof_pkg::REG_FILTER_ENABLE:    filt_en_q <= cfg_i.data[0];
        tawof_pkg::REG_TURN_THR_ONE:     thr1_q    <= cfg_i.data;
        tawof_pkg::REG_TURN_THR_TWO:     thr2_q    <= cfg_i.data;
        tawof_pkg::REG_TURN_THR_THREE:   thr3_q    <= cfg_i.data;
        tawof_pkg::REG_MEDIUM_SKIP_GAIN: gain_q    <= cfg_i.data[7:0];
        tawof_pkg::REG_BASE_SKIP_DIST:   bsd_q     <= cfg_i.data;
        tawof_pkg::REG_WHEEL_BASE:       wb_q      <= cfg_i.data[10:0];
        tawof_pkg::REG_MAX_STEER:        ms_q      <= cfg_i.data[13:0];
        default: ;
      endcase
    end
  end

  // skip distance squares, refreshed every cycle from the static registers
  logic [23:0] p_q;
  logic [47:0] psq_q;
  logic [31:0] bsq_q;
  always_ff @(posedge clk_i) begin
    p_q   <= 24'(bsd_q) * 24'(gain_q);
    psq_q <= 48'(p_q) * 48'(p_q);
    bsq_q <= 32'(bsd_q) * 32'(bsd_q);
  end

  // ---------------- pipeline control ----------------
  logic          en;
  logic          s1_vld_q, s2_vld_q, s3_vld_q, sa_vld_q, sb_vld_q, sc_vld_q, out_vld_q;
  logic [NS-1:0] cv_q;

  assign en           = !out_vld_q || result_o.ready;
  assign item_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      cv_q      <= '0;
      sa_vld_q  <= 1'b0;
      sb_vld_q  <= 1'b0;
      sc_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= item_i.valid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      cv_q      <= {cv_q[NS-2:0], s3_vld_q};
      sa_vld_q  <= cv_q[NS-1];
      sb_vld_q  <= sa_vld_q;
      sc_vld_q  <= sb_vld_q;
      out_vld_q <= sc_vld_q;
    end
  end

  // ---------------- stage 1: offsets, magnitudes, rotation start ----------------
  tawof_pkg::carry_t      c1_d, c1_q, c2_q, c3_q;
  logic signed [32:0]     dx_d, dy_d, dx1_q, dy1_q;
  logic signed [XW-1:0]   rx_d, ry_d, rx1_q, ry1_q, rx2_q, ry2_q, rx3_q, ry3_q;
  logic signed [ZW-1:0]   rz_d, rz1_q, rz2_q, rz3_q;
  logic [15:0]            mn, mx;
  logic [17:0]            mn3;

  always_comb begin
    c1_d.as        = item_i.steer_angle[14] ? 15'(-item_i.steer_angle)
                                            : 15'(item_i.steer_angle);
    c1_d.sp        = item_i.vehicle_speed[15] ? 16'(-item_i.vehicle_speed)
                                              : 16'(item_i.vehicle_speed);
    c1_d.steer_pos = !item_i.steer_angle[14] && (item_i.steer_angle != '0);
    c1_d.head      = item_i.vehicle_heading;
    c1_d.zero_st   = (c1_d.as == '0);
    c1_d.low       = (c1_d.sp <= 16'd25);
    mx             = (item_i.obj_width > item_i.obj_length) ? item_i.obj_width
                                                            : item_i.obj_length;
    mn             = (item_i.obj_width < item_i.obj_length) ? item_i.obj_width
                                                            : item_i.obj_length;
    mn3            = 18'(mn) + {1'b0, mn, 1'b0};
    c1_d.wall      = (mn >= 16'd3) && (18'(mx) > mn3) && (mn < 16'd256);

    dx_d = 33'(item_i.obj_x) - 33'(item_i.vehicle_x);
    dy_d = 33'(item_i.obj_y) - 33'(item_i.vehicle_y);

    // steer angle in Q30; past a quarter turn start from the y axis
    rz_d = $signed(ZW'({c1_d.as, 17'b0}));
    if (rz_d > tawof_pkg::ANG_HALF_PI) begin
      rx_d = '0;
      ry_d = tawof_pkg::CORDIC_ONE;
      rz_d = rz_d - tawof_pkg::ANG_HALF_PI;
    end else begin
      rx_d = tawof_pkg::CORDIC_ONE;
      ry_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q  <= c1_d;
      dx1_q <= dx_d;
      dy1_q <= dy_d;
      rx1_q <= rx_d;
      ry1_q <= ry_d;
      rz1_q <= rz_d;
    end
  end

  // ---------------- stage 2: abs, max, coarse normalize ----------------
  logic [32:0]        adx_w, ady_w;
  logic [31:0]        m_d, m2_q;
  logic signed [33:0] xs_d, ys_d, xs2_q, ys2_q, xs3_q, ys3_q;
  logic [23:0]        adx2_q, ady2_q;
  logic               huge2_q, zero2_q, huge3_q, zero3_q;

  always_comb begin
    adx_w = dx1_q[32] ? 33'(-dx1_q) : 33'(dx1_q);
    ady_w = dy1_q[32] ? 33'(-dy1_q) : 33'(dy1_q);
    m_d   = (adx_w > ady_w) ? adx_w[31:0] : ady_w[31:0];
    xs_d  = 34'(dx1_q);
    ys_d  = 34'(dy1_q);
    if (m_d[31:16] == '0) begin
      m_d  = m_d << 16;
      xs_d = xs_d <<< 16;
      ys_d = ys_d <<< 16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q    <= c1_q;
      rx2_q   <= rx1_q;
      ry2_q   <= ry1_q;
      rz2_q   <= rz1_q;
      m2_q    <= m_d;
      xs2_q   <= xs_d;
      ys2_q   <= ys_d;
      adx2_q  <= adx_w[23:0];
      ady2_q  <= ady_w[23:0];
      huge2_q <= (adx_w[31:24] != '0) || (ady_w[31:24] != '0);
      zero2_q <= (adx_w == '0) && (ady_w == '0);
    end
  end

  // ---------------- stage 3: fine normalize, squares ----------------
  logic [31:0]        m3;
  logic signed [33:0] xs3_d, ys3_d;
  logic [47:0]        sqx_q, sqy_q;

  always_comb begin
    m3    = m2_q;
    xs3_d = xs2_q;
    ys3_d = ys2_q;
    if (m3[31:24] == '0) begin
      m3 = m3 << 8; xs3_d = xs3_d <<< 8; ys3_d = ys3_d <<< 8;
    end
    if (m3[31:28] == '0) begin
      m3 = m3 << 4; xs3_d = xs3_d <<< 4; ys3_d = ys3_d <<< 4;
    end
    if (m3[31:30] == '0) begin
      m3 = m3 << 2; xs3_d = xs3_d <<< 2; ys3_d = ys3_d <<< 2;
    end
    if (!m3[31]) begin
      xs3_d = xs3_d <<< 1; ys3_d = ys3_d <<< 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_q    <= c2_q;
      rx3_q   <= rx2_q;
      ry3_q   <= ry2_q;
      rz3_q   <= rz2_q;
      xs3_q   <= xs3_d;
      ys3_q   <= ys3_d;
      huge3_q <= huge2_q;
      zero3_q <= zero2_q;
      sqx_q   <= 48'(adx2_q) * 48'(adx2_q);
      sqy_q   <= 48'(ady2_q) * 48'(ady2_q);
    end
  end

  // ---------------- CORDIC stages ----------------
  logic signed [XW-1:0] vx0, vy0, cx, cy, bx, by;
  logic signed [ZW-1:0] vz0, cz, bz;
  tawof_pkg::side_t     side_d;
  tawof_pkg::side_t     side_q [NS];

  always_comb begin
    // fold the left half plane onto the right one
    if (xs3_q < 0) begin
      vx0 = XW'(-xs3_q);
      vy0 = XW'(-ys3_q);
      vz0 = (ys3_q >= 0) ? tawof_pkg::ANG_PI : -tawof_pkg::ANG_PI;
    end else begin
      vx0 = XW'(xs3_q);
      vy0 = XW'(ys3_q);
      vz0 = '0;
    end
    side_d.c        = c3_q;
    side_d.huge     = huge3_q;
    side_d.zero_vec = zero3_q;
    side_d.d2       = 49'(sqx_q) + 49'(sqy_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < NS; k++) side_q[k] <= side_q[k-1];
    end
  end

  tawof_cordic u_rot (
    .clk_i       (clk_i),
    .en_i        (en),
    .vectoring_i (1'b0),
    .x_i         (rx3_q),
    .y_i         (ry3_q),
    .z_i         (rz3_q),
    .x_o         (cx),
    .y_o         (cy),
    .z_o         (cz)
  );

  tawof_cordic u_vec (
    .clk_i       (clk_i),
    .en_i        (en),
    .vectoring_i (1'b1),
    .x_i         (vx0),
    .y_i         (vy0),
    .z_i         (vz0),
    .x_o         (bx),
    .y_o         (by),
    .z_o         (bz)
  );

  // ---------------- stage A: quotient operands, raw heading difference ----------------
  tawof_pkg::side_t     sd;
  logic signed [XW-1:0] acx_w, acy_w;
  logic [10:0]          wbe;
  logic [13:0]          mse;
  logic [57:0]          n_d, na_q;
  logic [40:0]          d_d, da_q;
  logic signed [DW-1:0] diff_d, diffa_q;
  logic                 far1a_q, far2a_q, walla_q, stpa_q;

  always_comb begin
    sd    = side_q[NS-1];
    acx_w = (cx < 0) ? -cx : cx;
    acy_w = (cy < 0) ? -cy : cy;
    wbe   = (wb_q == '0) ? 11'd1 : wb_q;
    mse   = (ms_q == '0) ? 14'd1 : ms_q;
    if (sd.c.zero_st) begin
      n_d = '0;
      d_d = 41'd1;
    end else if (sd.c.low) begin
      n_d = 58'(31'(sd.c.as) * 31'(thr3_q));
      d_d = 41'(mse);
    end else begin
      n_d = {46'(sd.c.sp) * 46'(acy_w[29:0]), 12'b0};
      d_d = 41'(wbe) * 41'(acx_w[29:0]);
    end
    diff_d = (sd.zero_vec ? DW'(0) : DW'(bz)) - (DW'(sd.c.head) <<< 17);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      na_q    <= n_d;
      da_q    <= d_d;
      diffa_q <= diff_d;
      far1a_q <= sd.huge || (sd.d2 > 49'(bsq_q));
      far2a_q <= sd.huge || ({sd.d2, 8'b0} > 57'(psq_q));
      walla_q <= sd.c.wall;
      stpa_q  <= sd.c.steer_pos;
    end
  end

  // ---------------- stage B: threshold products, wrap ----------------
  logic [35:0]          pl1_q, pl2_q, pl3_q;
  logic [36:0]          ph1_q, ph2_q, ph3_q;
  logic [57:0]          nb_q;
  logic signed [DW-1:0] diffb_d, diffb_q;
  logic                 far1b_q, far2b_q, wallb_q, stpb_q;

  always_comb begin
    diffb_d = diffa_q;
    if (diffa_q > DW'(tawof_pkg::ANG_PI)) begin
      diffb_d = diffa_q - tawof_pkg::ANG_TWO_PI;
    end else if (diffa_q < -DW'(tawof_pkg::ANG_PI)) begin
      diffb_d = diffa_q + tawof_pkg::ANG_TWO_PI;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pl1_q   <= 36'(thr1_q) * 36'(da_q[19:0]);
      pl2_q   <= 36'(thr2_q) * 36'(da_q[19:0]);
      pl3_q   <= 36'(thr3_q) * 36'(da_q[19:0]);
      ph1_q   <= 37'(thr1_q) * 37'(da_q[40:20]);
      ph2_q   <= 37'(thr2_q) * 37'(da_q[40:20]);
      ph3_q   <= 37'(thr3_q) * 37'(da_q[40:20]);
      nb_q    <= na_q;
      diffb_q <= diffb_d;
      far1b_q <= far1a_q;
      far2b_q <= far2a_q;
      wallb_q <= walla_q;
      stpb_q  <= stpa_q;
    end
  end

  // ---------------- stage C: threshold compares, bearing tests ----------------
  logic [57:0] pt1, pt2, pt3;
  logic        ge1_q, ge2_q, ge3_q, inside_q, side_q2, far1c_q, far2c_q, wallc_q;

  assign pt1 = 58'({ph1_q, 20'b0}) + 58'(pl1_q);
  assign pt2 = 58'({ph2_q, 20'b0}) + 58'(pl2_q);
  assign pt3 = 58'({ph3_q, 20'b0}) + 58'(pl3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ge1_q    <= nb_q >= pt1;
      ge2_q    <= nb_q >= pt2;
      ge3_q    <= nb_q >= pt3;
      inside_q <= stpb_q ? (diffb_q > 0) : (diffb_q < 0);
      side_q2  <= (diffb_q > DW'(tawof_pkg::ANG_HALF_PI)) ||
                  (diffb_q < -DW'(tawof_pkg::ANG_HALF_PI));
      far1c_q  <= far1b_q;
      far2c_q  <= far2b_q;
      wallc_q  <= wallb_q;
    end
  end

  // ---------------- output stage ----------------
  logic [1:0] level_d, out_level_q;
  logic       filt_d, out_keep_q;

  always_comb begin
    level_d = ge3_q ? 2'd3 : (ge2_q ? 2'd2 : 2'd1);
    case (level_d)
      2'd3:    filt_d = inside_q || side_q2;
      2'd2:    filt_d = ((inside_q || side_q2) && wallc_q) || (inside_q && far2c_q);
      default: filt_d = inside_q && wallc_q && far1c_q;
    endcase
    // drop to pass-through when disabled or below the light threshold
    if (!filt_en_q || !ge1_q) begin
      level_d = 2'd0;
      filt_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_keep_q  <= !filt_d;
      out_level_q <= level_d;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.keep_object = out_keep_q;
  assign result_o.turn_level  = out_level_q;

`ifndef SYNTHESIS
  a_drop_needs_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_keep_q |-> out_level_q != 2'd0)
    else $error("filtered beat with inactive turn level");

  a_stall_holds_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !result_o.ready |=> $stable(cv_q) && $stable(sc_vld_q) && $stable(s1_vld_q))
    else $error("pipeline moved while result stalled");

  a_disabled_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !filt_en_q |-> out_keep_q && out_level_q == 2'd0)
    else $error("object dropped with filtering disabled");
`endif

endmodule
